// File: design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: first-fit slot run allocator definitions
// Sizes of the occupancy map, command and status codes shared by the
// interfaces and the allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	// pool geometry: the occupancy map is kept as rows of WORD_BITS slots
	localparam int SLOT_COUNT = 256;
	localparam int WORD_BITS  = 8;
	localparam int ROW_COUNT  = SLOT_COUNT / WORD_BITS;
	localparam int ROW_W      = $clog2(ROW_COUNT);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int SLOT_W     = 8;
	localparam int COUNT_W    = 9;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_BOUND = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD      = 2'd2
	} status_t;

endpackage

// File: design/ffa_req_if.sv
// ----------------------------------------------------------------------------
// ffa_req_if: allocator request channel
// Valid/ready channel carrying one command with its run count and slot index.
// ----------------------------------------------------------------------------
interface ffa_req_if import ffa_pkg::*; ();

	logic                valid;
	logic                ready;
	cmd_t                command;
	logic [COUNT_W-1:0]  run_count;
	logic [SLOT_W-1:0]   slot_index;

	modport source (output valid, command, run_count, slot_index, input ready);
	modport sink   (input valid, command, run_count, slot_index, output ready);

endinterface

// File: design/ffa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffa_rsp_if: allocator response channel
// Valid/ready channel carrying the status and data of one finished request.
// ----------------------------------------------------------------------------
interface ffa_rsp_if import ffa_pkg::*; ();

	logic                valid;
	logic                ready;
	status_t             status;
	logic [SLOT_W-1:0]   start_slot;
	logic                is_allocated;
	logic [COUNT_W-1:0]  high_water;

	modport source (output valid, status, start_slot, is_allocated, high_water, input ready);
	modport sink   (input valid, status, start_slot, is_allocated, high_water, output ready);

endinterface

// File: design/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/first_fit_slot_run_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_slot_run_allocator_top: first-fit contiguous slot allocator
// Occupancy map of SLOT_COUNT slots held in a RAM of WORD_BITS-wide rows,
// walked row by row by one shared row unit for allocate, free and queries.
// ----------------------------------------------------------------------------
//  channel   role    handshake     payload
//  req       sink    valid/ready   command, run_count, slot_index
//  rsp       source  valid/ready   status, start_slot, is_allocated, high_water
//
//  allocate: scans rows up to the fit, then marks the run's rows, bounded by
//  the one-row-per-cycle read of the map RAM
//  free / query slot: reads the slot's row; query bound: scans rows from the top
//  one request at a time; req.ready is low from accept until the response
//  is loaded into the output register, which holds it while rsp.ready is low
//  reset clears per-row valid bits, so every slot reads free at once
// ----------------------------------------------------------------------------
module first_fit_slot_run_allocator_top import ffa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ffa_req_if.sink    req,
	ffa_rsp_if.source  rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_BOUND,
		S_ACC,
		S_RESP
	} state_t;

	state_t                state_q;
	logic [ROW_W-1:0]      rd_row_q;
	logic [ROW_W-1:0]      rd_end_q;
	logic                  rd_up_q;
	logic                  rd_on_q;
	logic                  s1_vld_q;
	logic [ROW_W-1:0]      s1_row_q;
	logic [ROW_COUNT-1:0]  valid_q;

	cmd_t                  cmd_q;
	logic [COUNT_W-1:0]    count_q;
	logic [BIT_W-1:0]      idx_q;
	logic [COUNT_W-1:0]    run_q;
	logic [SLOT_W-1:0]     lo_q;
	logic [SLOT_W-1:0]     hi_q;

	status_t               res_status_q;
	logic [SLOT_W-1:0]     res_start_q;
	logic                  res_used_q;
	logic [COUNT_W-1:0]    res_hw_q;

	logic                  out_vld_q;
	status_t               out_status_q;
	logic [SLOT_W-1:0]     out_start_q;
	logic                  out_used_q;
	logic [COUNT_W-1:0]    out_hw_q;

	logic [WORD_BITS-1:0]  ram_rdata;
	logic [WORD_BITS-1:0]  word;
	logic                  ram_we;
	logic [WORD_BITS-1:0]  ram_wdata;

	logic [COUNT_W-1:0]    scan_run;
	logic                  scan_fnd;
	logic [BIT_W-1:0]      scan_pos;
	logic [SLOT_W-1:0]     scan_last;
	logic [SLOT_W-1:0]     scan_start;
	logic [WORD_BITS-1:0]  mark_mask;
	logic [BIT_W-1:0]      bnd_top;
	logic [COUNT_W-1:0]    bnd_hw;
	logic                  acc_bit;
	logic [WORD_BITS-1:0]  acc_sel;
	logic                  rd_kill;

	ffa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (ROW_COUNT)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (s1_row_q),
		.wdata (ram_wdata),
		.raddr (rd_row_q),
		.rdata (ram_rdata)
	);

	// rows never written read as all free
	assign word = valid_q[s1_row_q] ? ram_rdata : '0;

	// run tracking across one row, lowest slot first
	always_comb begin
		scan_run = run_q;
		scan_fnd = 1'b0;
		scan_pos = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (!scan_fnd) begin
				if (word[j]) begin
					scan_run = '0;
				end else begin
					scan_run = scan_run + COUNT_W'(1);
				end
				if (scan_run == count_q) begin
					scan_fnd = 1'b1;
					scan_pos = BIT_W'(j);
				end
			end
		end
	end

	assign scan_last  = {s1_row_q, scan_pos};
	assign scan_start = SLOT_W'({1'b0, scan_last} + COUNT_W'(1) - count_q);

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			mark_mask[j] = ({s1_row_q, BIT_W'(j)} >= lo_q) && ({s1_row_q, BIT_W'(j)} <= hi_q);
		end
	end

	always_comb begin
		bnd_top = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (word[j]) begin
				bnd_top = BIT_W'(j);
			end
		end
	end

	assign bnd_hw = COUNT_W'({s1_row_q, bnd_top}) + COUNT_W'(1);

	always_comb begin
		acc_sel = '0;
		acc_sel[idx_q] = 1'b1;
	end

	assign acc_bit = |(word & acc_sel);

	// sequencer takes the row reader over: fit found or bound found
	assign rd_kill = s1_vld_q && ((state_q == S_SCAN && scan_fnd) || (state_q == S_BOUND && |word));

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = word | mark_mask;
		if (state_q == S_MARK && s1_vld_q) begin
			ram_we = 1'b1;
		end
		if (state_q == S_ACC && s1_vld_q && cmd_q == CMD_FREE && acc_bit) begin
			ram_we    = 1'b1;
			ram_wdata = word & ~acc_sel;
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_vld_q;
	assign rsp.status       = out_status_q;
	assign rsp.start_slot   = out_start_q;
	assign rsp.is_allocated = out_used_q;
	assign rsp.high_water   = out_hw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_on_q   <= 1'b0;
			s1_vld_q  <= 1'b0;
			valid_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// shared row reader: one row a cycle until rd_kill stops it, data in the next cycle
			s1_row_q <= rd_row_q;
			if (!rd_kill) begin
				s1_vld_q <= rd_on_q;
				if (rd_on_q) begin
					if (rd_row_q == rd_end_q) begin
						rd_on_q <= 1'b0;
					end else begin
						rd_row_q <= rd_up_q ? rd_row_q + ROW_W'(1) : rd_row_q - ROW_W'(1);
					end
				end
			end

			if (ram_we) begin
				valid_q[s1_row_q] <= 1'b1;
			end

			if (out_vld_q && rsp.ready && state_q != S_RESP) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q        <= req.command;
						count_q      <= req.run_count;
						idx_q        <= req.slot_index[BIT_W-1:0];
						run_q        <= '0;
						res_status_q <= ST_OK;
						res_start_q  <= '0;
						res_used_q   <= 1'b0;
						res_hw_q     <= '0;
						case (req.command)
							CMD_ALLOC: begin
								if (req.run_count == '0) begin
									res_status_q <= ST_BAD;
									state_q      <= S_RESP;
								end else if (req.run_count > COUNT_W'(SLOT_COUNT)) begin
									res_status_q <= ST_NO_SPACE;
									state_q      <= S_RESP;
								end else begin
									rd_row_q <= '0;
									rd_end_q <= ROW_W'(ROW_COUNT - 1);
									rd_up_q  <= 1'b1;
									rd_on_q  <= 1'b1;
									state_q  <= S_SCAN;
								end
							end
							CMD_FREE, CMD_QUERY: begin
								rd_row_q <= req.slot_index[SLOT_W-1:BIT_W];
								rd_end_q <= req.slot_index[SLOT_W-1:BIT_W];
								rd_up_q  <= 1'b1;
								rd_on_q  <= 1'b1;
								state_q  <= S_ACC;
							end
							CMD_BOUND: begin
								rd_row_q <= ROW_W'(ROW_COUNT - 1);
								rd_end_q <= '0;
								rd_up_q  <= 1'b0;
								rd_on_q  <= 1'b1;
								state_q  <= S_BOUND;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (s1_vld_q) begin
						if (scan_fnd) begin
							// fit found: sweep the run's rows and set its bits
							lo_q        <= scan_start;
							hi_q        <= scan_last;
							res_start_q <= scan_start;
							rd_row_q    <= scan_start[SLOT_W-1:BIT_W];
							rd_end_q    <= s1_row_q;
							rd_up_q     <= 1'b1;
							rd_on_q     <= 1'b1;
							s1_vld_q    <= 1'b0;
							state_q     <= S_MARK;
						end else begin
							run_q <= scan_run;
							if (s1_row_q == ROW_W'(ROW_COUNT - 1)) begin
								res_status_q <= ST_NO_SPACE;
								state_q      <= S_RESP;
							end
						end
					end
				end
				S_MARK: begin
					if (s1_vld_q && s1_row_q == hi_q[SLOT_W-1:BIT_W]) begin
						state_q <= S_RESP;
					end
				end
				S_BOUND: begin
					if (s1_vld_q) begin
						if (|word) begin
							res_hw_q <= bnd_hw;
							rd_on_q  <= 1'b0;
							s1_vld_q <= 1'b0;
							state_q  <= S_RESP;
						end else if (s1_row_q == '0) begin
							state_q <= S_RESP;
						end
					end
				end
				S_ACC: begin
					if (s1_vld_q) begin
						if (cmd_q == CMD_FREE) begin
							res_status_q <= acc_bit ? ST_OK : ST_BAD;
						end else begin
							res_used_q <= acc_bit;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q    <= 1'b1;
						out_status_q <= res_status_q;
						out_start_q  <= res_start_q;
						out_used_q   <= res_used_q;
						out_hw_q     <= res_hw_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the map is only written by the mark sweep or a free
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_MARK || state_q == S_ACC))
		else $error("map write outside mark or free");

	// a new run never lands on a used slot
	a_mark_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK && s1_vld_q) |-> ((word & mark_mask) == '0))
		else $error("allocate marks an already used slot");

	// no row read left in flight when a request is taken
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> (!rd_on_q && !s1_vld_q))
		else $error("request accepted with row reads pending");

	// failed requests report no start slot
	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.start_slot == '0 && !rsp.is_allocated))
		else $error("failed request carries data");

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: first-fit slot run allocator
// Sends allocate, free and query requests with bursty pacing against a
// randomly stalling response side, predicts every response from an own copy
// of the occupancy map and compares each response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import ffa_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   start_slot;
		logic                is_allocated;
		logic [COUNT_W-1:0]  high_water;
	} alloc_result_t;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_PERIODIC,
		RX_SPARSE
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	ffa_req_if req ();
	ffa_rsp_if rsp ();

	first_fit_slot_run_allocator_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic [SLOT_COUNT-1:0] slot_map;
	alloc_result_t         expected_responses[$];
	int                    error_count = 0;
	int                    response_count = 0;
	int                    cycle_count = 0;
	int                    burst_left = 0;
	int                    hold_off_request = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// first-fit allocator behavior on the local copy of the occupancy map
	function automatic alloc_result_t predict_response(cmd_t command,
			logic [COUNT_W-1:0] run_count, logic [SLOT_W-1:0] slot_index);
		alloc_result_t r;
		int need, run_len, start, i, top;
		r = '{ST_OK, '0, 1'b0, '0};
		need = run_count;
		case (command)
			CMD_ALLOC: begin
				if (need == 0) begin
					r.status = ST_BAD;
				end else begin
					start = -1;
					run_len = 0;
					if (need <= SLOT_COUNT) begin
						for (i = 0; i < SLOT_COUNT && start < 0; i++) begin
							if (slot_map[i]) begin
								run_len = 0;
							end else begin
								run_len++;
								if (run_len == need)
									start = i + 1 - need;
							end
						end
					end
					if (start < 0) begin
						r.status = ST_NO_SPACE;
					end else begin
						for (i = start; i < start + need; i++)
							slot_map[i] = 1'b1;
						r.start_slot = SLOT_W'(start);
					end
				end
			end
			CMD_FREE: begin
				if (slot_index < SLOT_COUNT && slot_map[slot_index])
					slot_map[slot_index] = 1'b0;
				else
					r.status = ST_BAD;
			end
			CMD_QUERY: begin
				if (slot_index < SLOT_COUNT)
					r.is_allocated = slot_map[slot_index];
				else
					r.status = ST_BAD;
			end
			CMD_BOUND: begin
				top = SLOT_COUNT;
				while (top > 0 && !slot_map[top-1])
					top--;
				r.high_water = COUNT_W'(top);
			end
			default: begin
				r.status = ST_BAD;
			end
		endcase
		return r;
	endfunction

	// offer one request, record its expected response once accepted, then pace
	task automatic send_request(input cmd_t command, input logic [COUNT_W-1:0] run_count,
			input logic [SLOT_W-1:0] slot_index);
		int gap;
		req.valid      <= 1'b1;
		req.command    <= command;
		req.run_count  <= run_count;
		req.slot_index <= slot_index;
		do @(posedge clk); while (req.ready !== 1'b1);
		expected_responses.push_back(predict_response(command, run_count, slot_index));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic int pick_used_slot();
		int base, i;
		base = $urandom_range(0, SLOT_COUNT - 1);
		for (i = 0; i < SLOT_COUNT; i++)
			if (slot_map[(base + i) % SLOT_COUNT])
				return (base + i) % SLOT_COUNT;
		return base;
	endfunction

	// one random request; non-allocate commands carry noise in the unused fields
	task automatic send_random_request(input int alloc_pct, input int free_pct);
		int roll, size_roll;
		logic [COUNT_W-1:0] count;
		logic [SLOT_W-1:0] index;
		roll  = $urandom_range(0, 99);
		count = COUNT_W'($urandom_range(0, 511));
		index = SLOT_W'($urandom_range(0, 255));
		if (roll < alloc_pct) begin
			size_roll = $urandom_range(0, 99);
			if (size_roll < 3)
				count = ($urandom_range(0, 1) != 0) ? '0
					: COUNT_W'($urandom_range(SLOT_COUNT + 1, 511));
			else if (size_roll < 73)
				count = COUNT_W'($urandom_range(1, 8));
			else if (size_roll < 93)
				count = COUNT_W'($urandom_range(9, 40));
			else
				count = COUNT_W'($urandom_range(41, SLOT_COUNT));
			send_request(CMD_ALLOC, count, index);
		end else if (roll < alloc_pct + free_pct) begin
			if ($urandom_range(0, 99) < 85)
				index = SLOT_W'(pick_used_slot());
			send_request(CMD_FREE, count, index);
		end else if ((roll - alloc_pct - free_pct) % 3 != 0) begin
			if ($urandom_range(0, 1) != 0)
				index = SLOT_W'(pick_used_slot());
			send_request(CMD_QUERY, count, index);
		end else begin
			send_request(CMD_BOUND, count, index);
		end
	endtask

	// free a stretch of consecutive used slots, as a client returning a run
	task automatic release_run();
		int first, len;
		first = pick_used_slot();
		len = $urandom_range(1, 8);
		while (len > 0 && first < SLOT_COUNT && slot_map[first]) begin
			send_request(CMD_FREE, COUNT_W'($urandom_range(0, 511)), SLOT_W'(first));
			first++;
			len--;
		end
	endtask

	task automatic test_directed_cases();
		send_request(CMD_BOUND, 9'd0, 8'd0);
		send_request(CMD_QUERY, 9'd0, 8'd0);
		send_request(CMD_QUERY, 9'h1ff, 8'd255);
		send_request(CMD_FREE, 9'd0, 8'd7);
		send_request(CMD_ALLOC, 9'd0, 8'd0);
		send_request(CMD_ALLOC, 9'd511, 8'd255);
		send_request(CMD_ALLOC, 9'd257, 8'd0);
		// whole pool in one run, then full-pool corner cases
		send_request(CMD_ALLOC, 9'd256, 8'd0);
		send_request(CMD_BOUND, 9'd0, 8'd0);
		send_request(CMD_QUERY, 9'd0, 8'd255);
		send_request(CMD_ALLOC, 9'd1, 8'd0);
		send_request(CMD_FREE, 9'd0, 8'd255);
		send_request(CMD_FREE, 9'd0, 8'd255);
		send_request(CMD_BOUND, 9'd0, 8'd0);
		send_request(CMD_FREE, 9'd0, 8'd0);
		send_request(CMD_FREE, 9'd0, 8'd128);
		// three single holes: a run of two must not fit
		send_request(CMD_ALLOC, 9'd2, 8'd0);
		send_request(CMD_ALLOC, 9'd1, 8'd0);
		send_request(CMD_ALLOC, 9'd1, 8'd0);
		send_request(CMD_ALLOC, 9'd1, 8'd0);
		send_request(CMD_BOUND, 9'd0, 8'd0);
	endtask

	task automatic test_drain_to_empty();
		int i;
		for (i = 0; i < SLOT_COUNT; i++)
			if (slot_map[i])
				send_request(CMD_FREE, COUNT_W'($urandom_range(0, 511)), SLOT_W'(i));
		send_request(CMD_BOUND, 9'd0, 8'd0);
		send_request(CMD_QUERY, 9'd0, 8'd0);
	endtask

	task automatic test_fill_and_release();
		repeat (4) begin
			repeat (90) send_random_request(70, 15);
			repeat (15) release_run();
		end
	endtask

	task automatic test_fragmented_churn();
		repeat (450) send_random_request(40, 40);
	endtask

	// response side held off for a long stretch while requests keep coming
	task automatic test_input_stall();
		hold_off_request = 1500;
		repeat (150) send_random_request(45, 35);
	endtask

	task automatic test_mixed_random();
		repeat (250) send_random_request(30, 30);
	endtask

	initial begin
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.command    <= CMD_BOUND;
		req.run_count  <= '0;
		req.slot_index <= '0;
		slot_map = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_drain_to_empty();
		test_fill_and_release();
		test_drain_to_empty();
		test_fragmented_churn();
		test_input_stall();
		test_mixed_random();

		if (req.valid)
			req.valid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_responses.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// response side: ready pattern changes after each span of random length
	initial begin
		stall_mode_t mode;
		int span, tick, hold_left;
		tick = 0;
		hold_left = 0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(posedge clk);
				tick++;
				if (hold_off_request > 0) begin
					hold_left = hold_off_request;
					hold_off_request = 0;
				end
				if (hold_left > 0) begin
					rsp.ready <= 1'b0;
					hold_left--;
				end else begin
					case (mode)
						RX_ALWAYS:   rsp.ready <= 1'b1;
						RX_COIN:     rsp.ready <= ($urandom_range(0, 1) != 0);
						RX_PERIODIC: rsp.ready <= (tick % 4 != 0);
						default:     rsp.ready <= ($urandom_range(0, 7) == 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			response_count++;
			if (expected_responses.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("response %0d: no request outstanding", response_count);
			end else begin
				want = expected_responses.pop_front();
				if (rsp.status !== want.status || rsp.start_slot !== want.start_slot
						|| rsp.is_allocated !== want.is_allocated
						|| rsp.high_water !== want.high_water) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display({"response %0d mismatch: status %0d/%0d start %0d/%0d ",
							"allocated %0d/%0d high_water %0d/%0d (expected/actual)"},
							response_count, want.status, rsp.status,
							want.start_slot, rsp.start_slot,
							want.is_allocated, rsp.is_allocated,
							want.high_water, rsp.high_water);
				end
			end
		end
	end

endmodule
